@@ design/ssr_pkg.sv @@
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared constants, request codes, job and state types of the sprite
// scanline renderer.
// ----------------------------------------------------------------------------
package ssr_pkg;

  localparam int PATTERN_BYTES    = 8192;
  localparam int PAT_PLANE_DEPTH  = PATTERN_BYTES / 2;
  localparam int PAT_PLANE_AW     = $clog2(PAT_PLANE_DEPTH);
  localparam int SPRITE_COUNT_DEF = 64;
  localparam int QUEUE_DEPTH_DEF  = 2;
  localparam int SPRITE_LANES     = 4;

  localparam logic [1:0] REQ_WR_PATTERN = 2'd0;
  localparam logic [1:0] REQ_WR_SPRITE  = 2'd1;
  localparam logic [1:0] REQ_RENDER     = 2'd2;

  localparam logic [1:0] LANE_YPOS = 2'd0;
  localparam logic [1:0] LANE_TILE = 2'd1;
  localparam logic [1:0] LANE_ATTR = 2'd2;
  localparam logic [1:0] LANE_XPOS = 2'd3;

  localparam int ATTR_FLIP_BIT = 6;

  // one sprite row waiting for its pattern fetch
  typedef struct packed {
    logic [PAT_PLANE_AW-1:0] row_addr;  // {table, tile, row}
    logic [1:0]              pal;
    logic                    flip;
    logic [7:0]              xpos;
  } ssr_job_t;

  typedef struct packed {
    logic                    en;
    logic                    plane;
    logic [PAT_PLANE_AW-1:0] addr;
    logic [7:0]              data;
  } ssr_pat_wr_t;

  typedef enum logic {
    F_IDLE,
    F_CHECK
  } ssr_fstate_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_FETCH,
    B_EMIT
  } ssr_bstate_t;

endpackage

@@ design/ssr_if.sv @@
// ----------------------------------------------------------------------------
// ssr_if
// Channel interfaces: request words, pixel words and the config write.
// ----------------------------------------------------------------------------
interface ssr_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [12:0] write_addr;
  logic [7:0] write_data;
  logic [5:0] sprite_index;
  logic [8:0] scanline;

  modport source (
    output valid, req_type, write_addr, write_data, sprite_index, scanline,
    input  ready
  );
  modport sink (
    input  valid, req_type, write_addr, write_data, sprite_index, scanline,
    output ready
  );
endinterface

interface ssr_pix_if;
  logic       valid;
  logic       ready;
  logic [8:0] pixel_x;
  logic [4:0] palette_index;
  logic       opaque;
  logic       last;

  modport source (
    output valid, pixel_x, palette_index, opaque, last,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, palette_index, opaque, last,
    output ready
  );
endinterface

interface ssr_cfg_if;
  logic valid;
  logic ready;
  logic pattern_table_select;

  modport source (
    output valid, pattern_table_select,
    input  ready
  );
  modport sink (
    input  valid, pattern_table_select,
    output ready
  );
endinterface

@@ design/ssr_ram.sv @@
// ----------------------------------------------------------------------------
// ssr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/ssr_fifo.sv @@
// ----------------------------------------------------------------------------
// ssr_fifo
// Short job queue between the request front end and the pixel back end.
// ----------------------------------------------------------------------------
module ssr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full && !pop |-> !push)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue pop while empty");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> !empty)
    else $error("queue lost a word");

endmodule

@@ design/ssr_front.sv @@
// ----------------------------------------------------------------------------
// ssr_front
// Request front end: loads both stores, reads the sprite entry of a render
// word, tests the scanline and queues a row job on a hit.
// ----------------------------------------------------------------------------
module ssr_front #(
  parameter int SPRITE_COUNT = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  ssr_req_if.sink                req,
  ssr_cfg_if.sink                cfg,
  output ssr_pkg::ssr_pat_wr_t   pat_wr,
  output logic                   q_push,
  output ssr_pkg::ssr_job_t      q_job,
  input  logic                   q_full,
  input  logic                   q_empty
);

  import ssr_pkg::*;

  localparam int IW        = $clog2(SPRITE_COUNT);
  localparam int SPR_BYTES = SPRITE_COUNT * SPRITE_LANES;

  ssr_fstate_t state;
  ssr_fstate_t state_next;

  logic       table_sel;
  logic [8:0] scanline_q;
  logic       accept;
  logic       spr_re;
  logic [SPRITE_LANES-1:0] lane_we;
  logic [7:0] spr_rd [SPRITE_LANES];
  logic [9:0] diff;
  logic       hit;

  assign accept = req.valid && req.ready;

  assign diff = {1'b0, scanline_q} - {2'b00, spr_rd[LANE_YPOS]};
  assign hit  = !diff[9] && (diff[8:3] == '0);

  assign q_job.row_addr = {table_sel, spr_rd[LANE_TILE], diff[2:0]};
  assign q_job.pal      = spr_rd[LANE_ATTR][1:0];
  assign q_job.flip     = spr_rd[LANE_ATTR][ATTR_FLIP_BIT];
  assign q_job.xpos     = spr_rd[LANE_XPOS];

  assign cfg.ready = 1'b1;

  // pattern writes wait until no queued job still has to read pattern memory
  assign req.ready = (state == F_IDLE) && ((req.req_type != REQ_WR_PATTERN) || q_empty);

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (spr_re) begin
          state_next = F_CHECK;
        end
      end
      F_CHECK: begin
        if (!hit || !q_full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    pat_wr.en    = 1'b0;
    pat_wr.plane = req.write_addr[3];
    pat_wr.addr  = {req.write_addr[12:4], req.write_addr[2:0]};
    pat_wr.data  = req.write_data;
    lane_we      = '0;
    spr_re       = 1'b0;
    q_push       = 1'b0;
    case (state)
      F_IDLE: begin
        if (accept) begin
          case (req.req_type)
            REQ_WR_PATTERN: pat_wr.en = 1'b1;
            REQ_WR_SPRITE: begin
              if (req.write_addr < 13'(SPR_BYTES)) begin
                lane_we[req.write_addr[1:0]] = 1'b1;
              end
            end
            REQ_RENDER: spr_re = ({1'b0, req.sprite_index} < 7'(SPRITE_COUNT));
            default: ;
          endcase
        end
      end
      F_CHECK: q_push = hit && !q_full;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      table_sel <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        table_sel <= cfg.pattern_table_select;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (spr_re) begin
      scanline_q <= req.scanline;
    end
  end

  for (genvar i = 0; i < SPRITE_LANES; i++) begin : g_lane
    ssr_ram #(
      .WIDTH(8),
      .DEPTH(SPRITE_COUNT)
    ) u_spr_ram (
      .clk  (clk),
      .we   (lane_we[i]),
      .waddr(req.write_addr[IW+1:2]),
      .wdata(req.write_data),
      .re   (spr_re),
      .raddr(req.sprite_index[IW-1:0]),
      .rdata(spr_rd[i])
    );
  end

  a_push_from_check: assert property (@(posedge clk) disable iff (rst)
    q_push |-> state == F_CHECK)
    else $error("job pushed outside the check cycle");

  a_pat_wr_quiet: assert property (@(posedge clk) disable iff (rst)
    pat_wr.en |-> q_empty)
    else $error("pattern write while a job is pending");

  a_check_follows_read: assert property (@(posedge clk) disable iff (rst)
    spr_re |=> state == F_CHECK)
    else $error("sprite read not followed by check");

  a_check_blocks: assert property (@(posedge clk) disable iff (rst)
    state == F_CHECK |-> !req.ready)
    else $error("request taken during check");

endmodule

@@ design/ssr_back.sv @@
// ----------------------------------------------------------------------------
// ssr_back
// Pixel back end: pops a row job, fetches both bit planes from pattern
// memory and sends eight pixel words.
// ----------------------------------------------------------------------------
module ssr_back (
  input  logic                 clk,
  input  logic                 rst,
  input  ssr_pkg::ssr_pat_wr_t pat_wr,
  input  ssr_pkg::ssr_job_t    q_job,
  input  logic                 q_empty,
  output logic                 q_pop,
  ssr_pix_if.source            pix
);

  import ssr_pkg::*;

  ssr_bstate_t state;
  ssr_bstate_t state_next;

  logic [7:0] xpos;
  logic [1:0] pal;
  logic       flip;
  logic [7:0] lo;
  logic [7:0] hi;
  logic [2:0] k;
  logic [7:0] rd_lo;
  logic [7:0] rd_hi;
  logic [1:0] planes;
  logic       pix_take;

  assign pix_take = pix.valid && pix.ready;

  // pixel k uses plane bit 7-k, which is ~k on three bits
  assign planes            = {hi[~k], lo[~k]};
  assign pix.pixel_x       = {1'b0, xpos} + {6'b0, (flip ? ~k : k)};
  assign pix.palette_index = {1'b1, pal, planes};
  assign pix.opaque        = |planes;
  assign pix.last          = (k == 3'd7);

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          state_next = B_FETCH;
        end
      end
      B_FETCH: state_next = B_EMIT;
      B_EMIT: begin
        if (pix_take && pix.last) begin
          state_next = q_empty ? B_IDLE : B_FETCH;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    pix.valid = 1'b0;
    case (state)
      B_IDLE:  q_pop = !q_empty;
      B_FETCH: ;
      B_EMIT: begin
        pix.valid = 1'b1;
        q_pop     = pix_take && pix.last && !q_empty;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      if (state == B_FETCH) begin
        k <= '0;
      end else if (pix_take) begin
        k <= k + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      xpos <= q_job.xpos;
      pal  <= q_job.pal;
      flip <= q_job.flip;
    end
    if (state == B_FETCH) begin
      lo <= rd_lo;
      hi <= rd_hi;
    end
  end

  ssr_ram #(
    .WIDTH(8),
    .DEPTH(PAT_PLANE_DEPTH)
  ) u_pat_lo (
    .clk  (clk),
    .we   (pat_wr.en && !pat_wr.plane),
    .waddr(pat_wr.addr),
    .wdata(pat_wr.data),
    .re   (q_pop),
    .raddr(q_job.row_addr),
    .rdata(rd_lo)
  );

  ssr_ram #(
    .WIDTH(8),
    .DEPTH(PAT_PLANE_DEPTH)
  ) u_pat_hi (
    .clk  (clk),
    .we   (pat_wr.en && pat_wr.plane),
    .waddr(pat_wr.addr),
    .wdata(pat_wr.data),
    .re   (q_pop),
    .raddr(q_job.row_addr),
    .rdata(rd_hi)
  );

  a_fetch_after_pop: assert property (@(posedge clk) disable iff (rst)
    state == B_FETCH |-> $past(q_pop))
    else $error("fetch without a popped job");

  a_row_continues: assert property (@(posedge clk) disable iff (rst)
    pix_take && !pix.last |=> pix.valid)
    else $error("pixel row cut short");

  a_fetch_starts_row: assert property (@(posedge clk) disable iff (rst)
    state == B_FETCH |=> pix.valid && k == 3'd0)
    else $error("row does not start at pixel zero");

endmodule

@@ design/sprite_scanline_renderer.sv @@
// ----------------------------------------------------------------------------
// sprite_scanline_renderer
// Sprite row pixel generator with pattern and sprite attribute memories.
// ----------------------------------------------------------------------------
// Channels: req takes request words (pattern byte write, sprite attribute
// byte write, render). pix sends one word per pixel, eight per rendered
// sprite row, last set on the eighth. cfg writes pattern_table_select; write
// it only while the block is idle.
// A pattern write is held off while a render job still waits for its
// pattern fetch. A render word is taken and its sprite entry read; the
// front end checks the entry in the following cycle and queues a hit,
// waiting while the queue is full. The back end pops a job, fetches both
// bit planes in its fetch state, then emits the eight pixels and pops the
// next queued job as the last one is taken. The front end takes no request
// while it checks a render word and runs ahead by up to QUEUE_DEPTH jobs.
// A stalled pix holds its word; the queue fills, then a hit stalls req.
// Reset (rst, synchronous) empties the queue, idles both ends and clears the
// table select; memory contents are kept and must be written before use.
// ----------------------------------------------------------------------------
module sprite_scanline_renderer #(
  parameter int SPRITE_COUNT = ssr_pkg::SPRITE_COUNT_DEF,
  parameter int QUEUE_DEPTH  = ssr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  ssr_cfg_if.sink   cfg,
  ssr_req_if.sink   req,
  ssr_pix_if.source pix
);

  import ssr_pkg::*;

  ssr_pat_wr_t pat_wr;
  ssr_job_t    push_job;
  ssr_job_t    head_job;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;

  ssr_front #(
    .SPRITE_COUNT(SPRITE_COUNT)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cfg    (cfg),
    .pat_wr (pat_wr),
    .q_push (q_push),
    .q_job  (push_job),
    .q_full (q_full),
    .q_empty(q_empty)
  );

  ssr_fifo #(
    .WIDTH($bits(ssr_job_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (push_job),
    .full (q_full),
    .pop  (q_pop),
    .dout (head_job),
    .empty(q_empty)
  );

  ssr_back u_back (
    .clk    (clk),
    .rst    (rst),
    .pat_wr (pat_wr),
    .q_job  (head_job),
    .q_empty(q_empty),
    .q_pop  (q_pop),
    .pix    (pix)
  );

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for sprite_scanline_renderer.
// A queue of request words feeds a clocked driver. Each word the block
// accepts updates a local model of the pattern and sprite memories, and
// each hit render adds eight expected pixel words. A clocked monitor checks
// every pixel word against the oldest expected one. The run has a directed
// block of corner cases, then four random phases under both table selects,
// one without gaps and one with a long pixel stall.
// ----------------------------------------------------------------------------
module tb;
  import ssr_pkg::*;

  localparam int SPRITE_COUNT = SPRITE_COUNT_DEF;
  localparam int SPRITE_BYTES = SPRITE_COUNT * SPRITE_LANES;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [4:0] SPRITE_PAL_BASE = 5'd16;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_WORDS = 112;
  localparam int STALL_CYCLES = 400;

  typedef struct packed {
    logic [1:0]  kind;
    logic [12:0] addr;
    logic [7:0]  data;
    logic [5:0]  idx;
    logic [8:0]  line;
  } req_word_t;

  typedef struct packed {
    logic [8:0] x;
    logic [4:0] pal;
    logic       opaque;
    logic       last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst;

  ssr_cfg_if cfg_bus ();
  ssr_req_if req_bus ();
  ssr_pix_if pix_bus ();

  sprite_scanline_renderer #(.SPRITE_COUNT(SPRITE_COUNT)) dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_bus),
    .req (req_bus),
    .pix (pix_bus)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // model of the block, updated as words are accepted
  logic [7:0] pat_mem [PATTERN_BYTES];
  logic [7:0] spr_mem [SPRITE_BYTES];
  logic       table_sel;
  pixel_t     pixels_due [$];

  // stimulus-side view of what has been written
  logic [7:0] plan_spr [SPRITE_BYTES];
  bit         plan_spr_ok [SPRITE_BYTES];
  bit         plan_pat_ok [PATTERN_BYTES];
  logic       plan_table;
  req_word_t  pending_reqs [$];

  req_word_t cur_word;
  pixel_t    want;
  bit        word_in_flight;
  bit        no_gaps;
  int        holds_wanted;
  int        holds_done;
  int        hold_left;
  int        words_queued;
  int        rows_drawn;
  int        rows_skipped;
  int        pixels_checked;
  int        mismatches;

  function automatic void apply_request(req_word_t w);
    logic [7:0]  y, tile, attr, x, lo, hi;
    logic [8:0]  row_off;
    logic [12:0] base;
    logic [1:0]  planes;
    pixel_t      p;
    case (w.kind)
      REQ_WR_PATTERN: pat_mem[w.addr] = w.data;
      REQ_WR_SPRITE: begin
        if (w.addr < SPRITE_BYTES) spr_mem[w.addr[7:0]] = w.data;
      end
      REQ_RENDER: begin
        if (w.idx < SPRITE_COUNT) begin
          y    = spr_mem[{w.idx, LANE_YPOS}];
          tile = spr_mem[{w.idx, LANE_TILE}];
          attr = spr_mem[{w.idx, LANE_ATTR}];
          x    = spr_mem[{w.idx, LANE_XPOS}];
          row_off = w.line - {1'b0, y};
          if (w.line >= {1'b0, y} && row_off < 9'd8) begin
            base = {table_sel, tile, 1'b0, row_off[2:0]};
            lo = pat_mem[base];
            hi = pat_mem[base | 13'h8];
            for (int k = 0; k < 8; k++) begin
              planes   = {hi[7-k], lo[7-k]};
              p.x      = attr[ATTR_FLIP_BIT] ? 9'(x) + 9'(7 - k) : 9'(x) + 9'(k);
              p.pal    = SPRITE_PAL_BASE + {1'b0, attr[1:0], planes};
              p.opaque = planes != 2'b00;
              p.last   = k == 7;
              pixels_due.push_back(p);
            end
            rows_drawn++;
          end else begin
            rows_skipped++;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [8:0] rand_line();
    return 9'($urandom_range(261));
  endfunction

  function automatic void queue_req(logic [1:0] kind, logic [12:0] addr, logic [7:0] data,
                                    logic [5:0] idx, logic [8:0] line);
    req_word_t w;
    w.kind = kind;
    w.addr = addr;
    w.data = data;
    w.idx  = idx;
    w.line = line;
    pending_reqs.push_back(w);
    words_queued++;
    if (kind == REQ_WR_PATTERN) begin
      plan_pat_ok[addr] = 1'b1;
    end else if (kind == REQ_WR_SPRITE && addr < SPRITE_BYTES) begin
      plan_spr[addr[7:0]] = data;
      plan_spr_ok[addr[7:0]] = 1'b1;
    end
  endfunction

  function automatic void write_sprite(logic [5:0] idx, logic [7:0] y, logic [7:0] tile,
                                       logic [7:0] attr, logic [7:0] x);
    queue_req(REQ_WR_SPRITE, 13'({idx, LANE_YPOS}), y, 6'($urandom), rand_line());
    queue_req(REQ_WR_SPRITE, 13'({idx, LANE_TILE}), tile, 6'($urandom), rand_line());
    queue_req(REQ_WR_SPRITE, 13'({idx, LANE_ATTR}), attr, 6'($urandom), rand_line());
    queue_req(REQ_WR_SPRITE, 13'({idx, LANE_XPOS}), x, 6'($urandom), rand_line());
  endfunction

  // fills any unwritten sprite or pattern byte the render will read
  function automatic void queue_render(logic [5:0] idx, logic [8:0] line, bit fresh);
    logic [7:0]  y;
    logic [8:0]  row_off;
    logic [12:0] pa;
    for (int l = 0; l < SPRITE_LANES; l++) begin
      if (!plan_spr_ok[{idx, 2'(l)}])
        queue_req(REQ_WR_SPRITE, 13'({idx, 2'(l)}), 8'($urandom), 6'($urandom), rand_line());
    end
    y = plan_spr[{idx, LANE_YPOS}];
    row_off = line - {1'b0, y};
    if (line >= {1'b0, y} && row_off < 9'd8) begin
      pa = {plan_table, plan_spr[{idx, LANE_TILE}], 1'b0, row_off[2:0]};
      if (fresh || !plan_pat_ok[pa])
        queue_req(REQ_WR_PATTERN, pa, 8'($urandom), 6'($urandom), rand_line());
      if (fresh || !plan_pat_ok[pa | 13'h8])
        queue_req(REQ_WR_PATTERN, pa | 13'h8, 8'($urandom), 6'($urandom), rand_line());
    end
    queue_req(REQ_RENDER, 13'($urandom), 8'($urandom), idx, line);
  endfunction

  function automatic void check_field(string name, logic [8:0] exp_val, logic [8:0] got);
    if (got !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got);
      mismatches++;
    end
  endfunction

  task automatic write_table_select(logic v);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.pattern_table_select <= v;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    table_sel = v;
    plan_table = v;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (pending_reqs.size() != 0 || word_in_flight ||
                              pixels_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_bus.valid <= 1'b0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        apply_request(cur_word);
        word_in_flight = 1'b0;
      end
      if (!req_bus.valid || req_bus.ready) begin
        if (pending_reqs.size() != 0 && (no_gaps || $urandom_range(99) >= 15)) begin
          cur_word = pending_reqs.pop_front();
          word_in_flight = 1'b1;
          req_bus.valid <= 1'b1;
          req_bus.req_type <= cur_word.kind;
          req_bus.write_addr <= cur_word.addr;
          req_bus.write_data <= cur_word.data;
          req_bus.sprite_index <= cur_word.idx;
          req_bus.scanline <= cur_word.line;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // pixel ready, with long holds on request
  always @(posedge clk) begin
    if (rst) begin
      pix_bus.ready <= 1'b0;
    end else if (holds_done != holds_wanted) begin
      holds_done <= holds_wanted;
      hold_left <= STALL_CYCLES;
      pix_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pix_bus.ready <= 1'b0;
    end else begin
      pix_bus.ready <= no_gaps || $urandom_range(99) >= 15;
    end
  end

  // pixel monitor
  always @(posedge clk) begin
    if (!rst && pix_bus.valid && pix_bus.ready) begin
      if (pixels_due.size() == 0) begin
        $error("pixel word with no expectation: pixel_x %0d", pix_bus.pixel_x);
        mismatches++;
      end else begin
        want = pixels_due.pop_front();
        pixels_checked++;
        check_field("pixel_x", want.x, pix_bus.pixel_x);
        check_field("palette_index", 9'(want.pal), 9'(pix_bus.palette_index));
        check_field("opaque", 9'(want.opaque), 9'(pix_bus.opaque));
        check_field("last", 9'(want.last), 9'(pix_bus.last));
      end
    end
  end

  initial begin
    #3_000_000;
    $display("sprite_scanline_renderer test failed");
    $finish;
  end

  initial begin
    int target;
    int pick;
    int y;
    int row;
    logic [5:0] idx;

    rst = 1'b1;
    cfg_bus.valid = 1'b0;
    cfg_bus.pattern_table_select = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.req_type = REQ_WR_PATTERN;
    req_bus.write_addr = '0;
    req_bus.write_data = '0;
    req_bus.sprite_index = '0;
    req_bus.scanline = '0;
    pix_bus.ready = 1'b0;
    table_sel = 1'b0;
    plan_table = 1'b0;
    no_gaps = 1'b0;
    holds_wanted = 0;
    holds_done = 0;
    hold_left = 0;
    word_in_flight = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // corner cases: flipped sprite at x 255, top and bottom lines, misses,
    // ignored words, every plane combination, transparent row
    write_sprite(6'd63, 8'd0, 8'd255, 8'h43, 8'd255);
    queue_req(REQ_WR_PATTERN, 13'd4080, 8'h55, 6'd0, 9'd0);
    queue_req(REQ_WR_PATTERN, 13'd4088, 8'h33, 6'd0, 9'd0);
    queue_render(6'd63, 9'd0, 1'b0);
    queue_req(REQ_UNUSED, 13'h1FFF, 8'hFF, 6'h3F, 9'd261);
    queue_req(REQ_WR_SPRITE, 13'h1FFF, 8'hFF, 6'h3F, 9'd261);
    queue_req(REQ_WR_SPRITE, 13'd256, 8'hAA, 6'd0, 9'd0);
    queue_req(REQ_WR_PATTERN, 13'h1FFF, 8'hFF, 6'h3F, 9'd261);
    queue_render(6'd63, 9'd8, 1'b0);
    queue_req(REQ_WR_PATTERN, 13'd4087, 8'h00, 6'd0, 9'd0);
    queue_req(REQ_WR_PATTERN, 13'd4095, 8'h00, 6'd0, 9'd0);
    queue_render(6'd63, 9'd7, 1'b0);
    write_sprite(6'd0, 8'd254, 8'd0, 8'h00, 8'd0);
    queue_req(REQ_WR_PATTERN, 13'd7, 8'hA5, 6'd0, 9'd0);
    queue_req(REQ_WR_PATTERN, 13'd15, 8'hFF, 6'd0, 9'd0);
    queue_render(6'd0, 9'd261, 1'b0);
    queue_render(6'd0, 9'd253, 1'b0);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      write_table_select(~ph[0]);
      no_gaps <= ph == 1;
      target = words_queued + PHASE_WORDS;
      while (words_queued < target) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          idx = 6'($urandom);
          if ($urandom_range(1) || !plan_spr_ok[{idx, LANE_YPOS}])
            write_sprite(idx, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
          y = plan_spr[{idx, LANE_YPOS}];
          repeat ($urandom_range(1, 3)) begin
            row = $urandom_range((261 - y) < 7 ? 261 - y : 7);
            queue_render(idx, 9'(y + row), 1'($urandom_range(1)));
          end
        end else if (pick < 75) begin
          queue_render(6'($urandom), rand_line(), 1'b0);
        end else if (pick < 85) begin
          queue_req(REQ_WR_PATTERN, 13'($urandom), 8'($urandom), 6'($urandom), rand_line());
        end else if (pick < 93) begin
          queue_req(REQ_WR_SPRITE, 13'($urandom), 8'($urandom), 6'($urandom), rand_line());
        end else begin
          queue_req(REQ_UNUSED, 13'($urandom), 8'($urandom), 6'($urandom), rand_line());
        end
      end
      if (ph == 2) holds_wanted <= holds_wanted + 1;
      wait_idle();
    end

    $display("Covered %0d request words: %0d sprite rows drawn, %0d renders off the line.",
             words_queued, rows_drawn, rows_skipped);
    $display("Checked %0d pixel words under both pattern tables, incl. a %0d-cycle pixel stall.",
             pixels_checked, STALL_CYCLES);
    if (mismatches == 0) begin
      $display("sprite_scanline_renderer test passed");
    end else begin
      $display("sprite_scanline_renderer test failed");
    end
    $finish;
  end

endmodule
